[hdl/lsac_pkg.sv]
// Shared types and constants for the LRU set-associative cache model.
// No dependencies; imported by the core and the lookup/update module.
package lsac_pkg;

    // default sizing handed to the top level parameters
    localparam int MAX_SET_BITS_DEF = 6;
    localparam int MAX_WAYS_DEF     = 8;
    localparam int ADDRESS_BITS_DEF = 32;

    // fixed field widths
    localparam int OP_W       = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;
    localparam int COUNT_W    = 32;
    localparam int SBITS_W    = 3;
    localparam int OFFSET_W   = 5;
    localparam int WAYSCFG_W  = 4;

    // access kinds
    localparam logic [OP_W-1:0] OP_LOAD   = 2'd0;
    localparam logic [OP_W-1:0] OP_STORE  = 2'd1;
    localparam logic [OP_W-1:0] OP_MODIFY = 2'd2;
    localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS        = 2'd2;

    // outcome of the first access of a request
    typedef struct packed {
        logic hit;
        logic evicted;
    } t_outcome;

endpackage

[hdl/lsac_lookup.sv]
// Tag compare and LRU update of one set row, purely combinational.
// Depends on lsac_pkg (t_outcome).
module lsac_lookup import lsac_pkg::*; #(
    parameter int MAX_WAYS     = MAX_WAYS_DEF,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
    input  logic [MAX_WAYS-1:0][ADDRESS_BITS-1:0]                        i_tags,
    input  logic [MAX_WAYS-1:0]                                          i_valid,
    input  logic [MAX_WAYS-1:0][((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] i_rank,
    input  logic [MAX_WAYS-1:0]                                          i_way_en,
    input  logic [ADDRESS_BITS-1:0]                                      i_tag,
    output logic [MAX_WAYS-1:0][ADDRESS_BITS-1:0]                        o_tags,
    output logic [MAX_WAYS-1:0]                                          o_valid,
    output logic [MAX_WAYS-1:0][((MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1)-1:0] o_rank,
    output t_outcome                                                     o_outcome
);

    localparam int RANK_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W  = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);

    logic [MAX_WAYS-1:0] match;
    logic                hit;
    logic [WAY_W-1:0]    hit_way;
    logic [RANK_W-1:0]   hit_rank;
    logic                have_free;
    logic [WAY_W-1:0]    free_way;
    logic                have_vic;
    logic [WAY_W-1:0]    vic_way;
    logic [RANK_W-1:0]   vic_rank;
    logic [WAY_W-1:0]    target;

    // tag compare over the ways in use
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            match[w] = i_way_en[w] & i_valid[w] & (i_tags[w] == i_tag);
        end
    end

    // lowest matching way, lowest free way
    always_comb begin
        hit       = 1'b0;
        hit_way   = '0;
        have_free = 1'b0;
        free_way  = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (i_way_en[w] && !i_valid[w]) begin
                have_free = 1'b1;
                free_way  = WAY_W'(w);
            end
        end
    end

    // LRU victim: largest rank, ties to the lowest way
    always_comb begin
        have_vic = 1'b0;
        vic_way  = '0;
        vic_rank = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (i_way_en[w] && i_valid[w] && (!have_vic || i_rank[w] > vic_rank)) begin
                have_vic = 1'b1;
                vic_way  = WAY_W'(w);
                vic_rank = i_rank[w];
            end
        end
    end

    assign hit_rank = i_rank[hit_way];
    assign target   = have_free ? free_way : vic_way;

    // updated row
    always_comb begin
        o_tags  = i_tags;
        o_valid = i_valid;
        o_rank  = i_rank;
        if (hit) begin
            for (int k = 0; k < MAX_WAYS; k++) begin
                if (WAY_W'(k) != hit_way && i_way_en[k] && i_valid[k] &&
                    i_rank[k] < hit_rank) begin
                    o_rank[k] = i_rank[k] + RANK_W'(1);
                end
            end
            o_rank[hit_way] = '0;
        end else begin
            for (int k = 0; k < MAX_WAYS; k++) begin
                if (WAY_W'(k) != target && i_way_en[k] && i_valid[k] &&
                    i_rank[k] < RANK_MAX) begin
                    o_rank[k] = i_rank[k] + RANK_W'(1);
                end
            end
            o_tags[target]  = i_tag;
            o_valid[target] = 1'b1;
            o_rank[target]  = '0;
        end
    end

    assign o_outcome.hit     = hit;
    assign o_outcome.evicted = !hit && !have_free;

endmodule

[hdl/lru_set_assoc_cache_sim_core.sv]
// Top level of the tag-only LRU set-associative cache model.
// Depends on lsac_pkg and lsac_lookup.
//
// One request (load, store, modify) is taken whenever start is high and busy
// is low, one per clock; its result appears with o_done, registered behind
// stage 1, and lasts one cycle, the receiver cannot stall it. The set row
// (tags, valid bits, ranks) is read from a registered row memory in stage 0
// and compared, updated and written back in stage 1; a request to the same
// set as the one just before it takes the updated row from a bypass. After
// reset busy stays high while the valid and rank memory is cleared one row a
// cycle, all 2^MAX_SET_BITS rows (64 by default); configuration writes are
// taken at all times. Totals wrap at 32 bits.
module lru_set_assoc_cache_sim_core import lsac_pkg::*; #(
    parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
    parameter int MAX_WAYS     = MAX_WAYS_DEF,
    parameter int ADDRESS_BITS = ADDRESS_BITS_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [OP_W-1:0]         i_operation,
    input  logic [ADDRESS_BITS-1:0] i_address,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [CFG_DATA_W-1:0]   i_cfg_data,
    output logic                    o_done,
    output logic                    o_hit,
    output logic                    o_miss,
    output logic                    o_evicted,
    output logic                    o_second_hit,
    output logic [COUNT_W-1:0]      o_hit_total,
    output logic [COUNT_W-1:0]      o_miss_total,
    output logic [COUNT_W-1:0]      o_evict_total
);

    localparam int NUM_SETS = 1 << MAX_SET_BITS;
    localparam int SET_W    = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int SHIFT_W  = 6;

    typedef logic [MAX_WAYS-1:0][ADDRESS_BITS-1:0] t_tag_row;
    typedef logic [MAX_WAYS-1:0][RANK_W-1:0]       t_rank_row;

    // configuration
    logic [SBITS_W-1:0]   r_cfg_sidx_bits;
    logic [OFFSET_W-1:0]  r_cfg_offset_bits;
    logic [WAYSCFG_W-1:0] r_cfg_ways;

    // clearing pass
    logic             r_clearing;
    logic [SET_W-1:0] r_clr_addr;

    // row memories
    t_tag_row            mem_tags  [NUM_SETS];
    logic [MAX_WAYS-1:0] mem_valid [NUM_SETS];
    t_rank_row           mem_rank  [NUM_SETS];

    // stage 1 (row read back, lookup)
    logic                    r_s1_valid;
    logic [OP_W-1:0]         r_s1_op;
    logic [ADDRESS_BITS-1:0] r_s1_tag;
    logic [SET_W-1:0]        r_s1_set;
    t_tag_row                r_rd_tags;
    logic [MAX_WAYS-1:0]     r_rd_valid;
    t_rank_row               r_rd_rank;
    logic                    r_byp;
    t_tag_row                r_byp_tags;
    logic [MAX_WAYS-1:0]     r_byp_valid;
    t_rank_row               r_byp_rank;

    // counters
    logic [COUNT_W-1:0] r_hit_cnt;
    logic [COUNT_W-1:0] r_miss_cnt;
    logic [COUNT_W-1:0] r_evict_cnt;

    logic                            accept;
    logic [SBITS_W-1:0]              s_eff;
    logic [SHIFT_W-1:0]              tag_shift;
    logic [SET_W-1:0]                set_mask;
    logic [ADDRESS_BITS+SET_W-1:0]   addr_sh;
    logic [SET_W-1:0]                n_set;
    logic [ADDRESS_BITS-1:0]         n_tag;
    logic [MAX_WAYS-1:0]             way_en;
    t_tag_row                        cur_tags;
    logic [MAX_WAYS-1:0]             cur_valid;
    t_rank_row                       cur_rank;
    t_tag_row                        n_tags;
    logic [MAX_WAYS-1:0]             n_valid;
    t_rank_row                       n_rank;
    t_outcome                        outcome;
    logic                            s1_access;
    logic                            s1_modify;

    assign accept = start && !busy;
    assign busy   = r_clearing;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_sidx_bits   <= '0;
            r_cfg_offset_bits <= '0;
            r_cfg_ways        <= WAYSCFG_W'(1);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SET_BITS:    r_cfg_sidx_bits   <= i_cfg_data[SBITS_W-1:0];
                CFG_OFFSET_BITS: r_cfg_offset_bits <= i_cfg_data[OFFSET_W-1:0];
                CFG_WAYS:        r_cfg_ways        <= i_cfg_data[WAYSCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // address split: set index and tag
    assign s_eff = (int'(r_cfg_sidx_bits) > MAX_SET_BITS) ? SBITS_W'(MAX_SET_BITS)
                                                          : r_cfg_sidx_bits;
    assign tag_shift = SHIFT_W'(s_eff) + SHIFT_W'(r_cfg_offset_bits);

    always_comb begin
        for (int i = 0; i < SET_W; i++) begin
            set_mask[i] = (i < int'(s_eff));
        end
    end

    assign addr_sh = {{SET_W{1'b0}}, i_address} >> r_cfg_offset_bits;
    assign n_set   = addr_sh[SET_W-1:0] & set_mask;
    assign n_tag   = i_address >> tag_shift;

    // ways taking part: below the configured count, at least one
    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            way_en[w] = (w == 0) || (5'(w) < {1'b0, r_cfg_ways});
        end
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + SET_W'(1);
            if (r_clr_addr == SET_W'(NUM_SETS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // stage 0: request register and row read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_byp      <= 1'b0;
        end else begin
            r_s1_valid <= accept;
            r_byp      <= accept && r_s1_valid && s1_access && (n_set == r_s1_set);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_op  <= i_operation;
            r_s1_tag <= n_tag;
            r_s1_set <= n_set;
        end
        r_byp_tags  <= n_tags;
        r_byp_valid <= n_valid;
        r_byp_rank  <= n_rank;
    end

    // row memories: registered read, write-back of the updated row
    always_ff @(posedge i_clk) begin
        r_rd_tags <= mem_tags[n_set];
        if (r_s1_valid && s1_access) begin
            mem_tags[r_s1_set] <= n_tags;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_valid <= mem_valid[n_set];
        r_rd_rank  <= mem_rank[n_set];
        if (r_clearing) begin
            mem_valid[r_clr_addr] <= '0;
            mem_rank[r_clr_addr]  <= '0;
        end else if (r_s1_valid && s1_access) begin
            mem_valid[r_s1_set] <= n_valid;
            mem_rank[r_s1_set]  <= n_rank;
        end
    end

    // stage 1: lookup on the current row
    assign cur_tags  = r_byp ? r_byp_tags  : r_rd_tags;
    assign cur_valid = r_byp ? r_byp_valid : r_rd_valid;
    assign cur_rank  = r_byp ? r_byp_rank  : r_rd_rank;

    assign s1_access = (r_s1_op != OP_NONE);
    assign s1_modify = (r_s1_op == OP_MODIFY);

    lsac_lookup #(
        .MAX_WAYS     (MAX_WAYS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_lookup (
        .i_tags    (cur_tags),
        .i_valid   (cur_valid),
        .i_rank    (cur_rank),
        .i_way_en  (way_en),
        .i_tag     (r_s1_tag),
        .o_tags    (n_tags),
        .o_valid   (n_valid),
        .o_rank    (n_rank),
        .o_outcome (outcome)
    );

    // running totals; a modify adds the hit of its repeated access
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
        end else if (r_s1_valid && s1_access) begin
            r_hit_cnt   <= r_hit_cnt + COUNT_W'(outcome.hit) + COUNT_W'(s1_modify);
            r_miss_cnt  <= r_miss_cnt + COUNT_W'(!outcome.hit);
            r_evict_cnt <= r_evict_cnt + COUNT_W'(outcome.evicted);
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_hit        <= s1_access && outcome.hit;
        o_miss       <= s1_access && !outcome.hit;
        o_evicted    <= s1_access && outcome.evicted;
        o_second_hit <= s1_modify;
    end

    assign o_hit_total   = r_hit_cnt;
    assign o_miss_total  = r_miss_cnt;
    assign o_evict_total = r_evict_cnt;

endmodule

[hdl/lsac_checker.sv]
// Port-level checks on the cache model core, attached by bind.
// Depends on lru_set_assoc_cache_sim_core port names only.
module lsac_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic start,
    input logic busy,
    input logic o_done,
    input logic o_hit,
    input logic o_miss,
    input logic o_evicted,
    input logic o_second_hit
);

    // every accepted request gives its result with o_done
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_done)
        else $error("accepted request gave no result");

    // no result without an earlier accepted request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 2))
        else $error("result without request");

    // hit and miss are exclusive
    a_hit_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !(o_hit && o_miss))
        else $error("hit and miss together");

    // eviction only on a miss
    a_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_evicted) |-> o_miss)
        else $error("eviction without miss");

    // a repeated access only follows a real first access
    a_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_second_hit) |-> (o_hit || o_miss))
        else $error("second access without first");

endmodule

bind lru_set_assoc_cache_sim_core lsac_checker u_lsac_checker (.*);
